// ===== rtl/core/segm_pkg.sv =====
// ----------------------------------------------------------------------------
// segm_pkg: shared types and constants of the exposure and gain mapper
// sensor type codes, the gain rom, and the word handed along the cell row
// ----------------------------------------------------------------------------
package segm_pkg;

   // sensor type codes
   localparam logic [1:0] TYPE_TABLE   = 2'd0;
   localparam logic [1:0] TYPE_RECIP   = 2'd1;
   localparam logic [1:0] TYPE_SCALED  = 2'd2;
   localparam logic [1:0] TYPE_UNKNOWN = 2'd3;

   localparam int EXPO_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int ECODE_W    = 22;
   localparam int EXPO_STEPS = ECODE_W;
   localparam int DIVIDEND_W = 27;
   localparam int EXPO_REM_W = 9;
   localparam int GAIN_STEPS = 9;
   localparam int GNUM_W     = 19;

   localparam logic [10:0] EXPO_MUL_RECIP  = 11'd1080;
   localparam logic [5:0]  EXPO_MUL_SCALED = 6'd39;
   localparam logic [EXPO_REM_W-1:0] EXPO_DIV_TABLE  = 9'd1;
   localparam logic [EXPO_REM_W-1:0] EXPO_DIV_RECIP  = 9'd33;
   localparam logic [EXPO_REM_W-1:0] EXPO_DIV_SCALED = 9'd500;

   localparam logic [GNUM_W-1:0] RECIP_NUM  = 19'd262144;
   localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd1024;
   localparam logic [GAIN_W-1:0] RECIP_BASE = 16'd256;

   localparam int ROM_ROWS  = 71;
   localparam int ROM_IDX_W = $clog2(ROM_ROWS);

   localparam logic [15:0] ROM_GAIN [ROM_ROWS] = '{
      16'd1024, 16'd1121, 16'd1223, 16'd1325, 16'd1427, 16'd1529, 16'd1631, 16'd1733,
      16'd1835, 16'd1937, 16'd2039, 16'd2141, 16'd2243, 16'd2345, 16'd2447, 16'd2549,
      16'd2651, 16'd2753, 16'd2855, 16'd2957, 16'd3059, 16'd3160, 16'd3262, 16'd3364,
      16'd3466, 16'd3568, 16'd3670, 16'd3772, 16'd3874, 16'd3976, 16'd4078, 16'd4180,
      16'd4282, 16'd4384, 16'd4486, 16'd4588, 16'd4690, 16'd4792, 16'd4894, 16'd4996,
      16'd5098, 16'd5200, 16'd5301, 16'd5403, 16'd5505, 16'd5607, 16'd5709, 16'd5811,
      16'd5913, 16'd6015, 16'd6117, 16'd6219, 16'd6321, 16'd6423, 16'd6525, 16'd6627,
      16'd6729, 16'd6831, 16'd6933, 16'd7035, 16'd7137, 16'd7239, 16'd7341, 16'd7442,
      16'd7544, 16'd7646, 16'd7748, 16'd7850, 16'd7952, 16'd8054, 16'd8192
   };

   localparam logic [7:0] ROM_CODE [ROM_ROWS] = '{
      8'h20, 8'h23, 8'h26, 8'h28, 8'h2A, 8'h2C, 8'h2E, 8'h30,
      8'h32, 8'h33, 8'h35, 8'h36, 8'h37, 8'h39, 8'h3A, 8'h3B,
      8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43,
      8'h44, 8'h45, 8'h46, 8'h46, 8'h47, 8'h48, 8'h49, 8'h49,
      8'h4A, 8'h4B, 8'h4B, 8'h4C, 8'h4D, 8'h4D, 8'h4E, 8'h4F,
      8'h4F, 8'h50, 8'h50, 8'h51, 8'h51, 8'h52, 8'h52, 8'h53,
      8'h53, 8'h54, 8'h54, 8'h55, 8'h55, 8'h56, 8'h56, 8'h57,
      8'h57, 8'h58, 8'h58, 8'h58, 8'h59, 8'h59, 8'h5A, 8'h5A,
      8'h5A, 8'h5B, 8'h5B, 8'h5C, 8'h5C, 8'h5C, 8'h5D
   };

   // word handed from cell to cell
   typedef struct packed {
      logic [1:0]            stype;
      logic [GAIN_W-1:0]     gain;
      logic [EXPO_REM_W-1:0] erem;
      logic [EXPO_STEPS-1:0] ebits;
      logic [GAIN_W-1:0]     grem;
      logic [GAIN_STEPS-1:0] gbits;
      logic [ROM_IDX_W-1:0]  sidx;
   } segm_lane_type;

   function automatic logic [15:0] segm_rom_gain(input logic [ROM_IDX_W-1:0] idx);
      logic [15:0] value;
      value = '1;
      if (idx < ROM_IDX_W'(ROM_ROWS)) begin
         value = ROM_GAIN[idx];
      end
      return value;
   endfunction

   function automatic logic [7:0] segm_rom_code(input logic [ROM_IDX_W-1:0] idx);
      logic [7:0] value;
      value = '0;
      if (idx < ROM_IDX_W'(ROM_ROWS)) begin
         value = ROM_CODE[idx];
      end
      return value;
   endfunction

   function automatic logic [EXPO_REM_W-1:0] segm_expo_divisor(input logic [1:0] stype);
      logic [EXPO_REM_W-1:0] value;
      unique case (stype)
         TYPE_RECIP:  value = EXPO_DIV_RECIP;
         TYPE_SCALED: value = EXPO_DIV_SCALED;
         default:     value = EXPO_DIV_TABLE;
      endcase
      return value;
   endfunction

endpackage

// ===== rtl/core/segm_cell.sv =====
// ----------------------------------------------------------------------------
// segm_cell: one cell of the mapper row
// one exposure quotient bit, plus, as DO_GAIN and DO_SEARCH select, one gain reciprocal bit and one rom search bit
// ----------------------------------------------------------------------------
module segm_cell #(
   parameter int STEP        = 0,
   parameter int SEARCH_BITS = 7,
   parameter int ROWS        = 71
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  segm_pkg::segm_lane_type in_lane,
   output logic                   out_valid,
   input  logic                   out_ready,
   output segm_pkg::segm_lane_type out_lane
);
   import segm_pkg::*;

   localparam bit DO_SEARCH = (STEP < SEARCH_BITS);
   localparam bit DO_GAIN   = (STEP >= (EXPO_STEPS - GAIN_STEPS));
   localparam int SBIT      = DO_SEARCH ? (SEARCH_BITS - 1 - STEP) : 0;
   localparam logic [ROM_IDX_W-1:0] PROBE_BIT = ROM_IDX_W'(1 << SBIT);
   localparam logic [ROM_IDX_W-1:0] LAST_ROW  = ROM_IDX_W'(ROWS - 1);

   logic                  valid_ff;
   segm_lane_type         lane_ff;
   segm_lane_type         lane_in;
   logic [EXPO_REM_W-1:0] ediv;
   logic [EXPO_REM_W:0]   etrial;
   logic                  eq;
   logic [GAIN_W:0]       gtrial;
   logic                  gq;
   logic [ROM_IDX_W-1:0]  probe;

   always_comb begin
      lane_in = in_lane;

      // exposure long division, one quotient bit
      ediv   = segm_expo_divisor(in_lane.stype);
      etrial = {in_lane.erem, in_lane.ebits[EXPO_STEPS-1]};
      eq     = (etrial >= {1'b0, ediv});
      if (eq) begin
         lane_in.erem = EXPO_REM_W'(etrial - {1'b0, ediv});
      end else begin
         lane_in.erem = etrial[EXPO_REM_W-1:0];
      end
      lane_in.ebits = {in_lane.ebits[EXPO_STEPS-2:0], eq};

      // reciprocal gain division, one quotient bit in the cells where DO_GAIN holds
      gtrial = {in_lane.grem, in_lane.gbits[GAIN_STEPS-1]};
      gq     = (gtrial >= {1'b0, in_lane.gain});
      if (DO_GAIN) begin
         if (gq) begin
            lane_in.grem = GAIN_W'(gtrial - {1'b0, in_lane.gain});
         end else begin
            lane_in.grem = gtrial[GAIN_W-1:0];
         end
         lane_in.gbits = {in_lane.gbits[GAIN_STEPS-2:0], gq};
      end

      // binary search over the gain rom, one index bit in the cells where DO_SEARCH holds
      probe = in_lane.sidx | PROBE_BIT;
      if (DO_SEARCH && (probe <= LAST_ROW)
            && (segm_rom_gain(ROM_IDX_W'(probe - 1'b1)) < in_lane.gain)) begin
         lane_in.sidx = probe;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
      end
   end

endmodule

// ===== rtl/core/sensor_exposure_gain_mapper.sv =====
// ----------------------------------------------------------------------------
// sensor_exposure_gain_mapper: auto exposure result to sensor register words
// maps exposure time and analog gain to the codes of the selected sensor type
// ----------------------------------------------------------------------------
// Takes one request word per clock while the response side is not stalled and
// returns one response word per request, in order. Each word passes an input
// register, a row of 22 cells and an output register; the row length is set by
// the 22-bit exposure quotient, which the cells build one bit each. Stalls on
// the response side are absorbed by the registers of the row, and requests keep
// being taken while the row has an empty place. The sensor type is sampled as a
// request is taken; write it only while no words are in flight.
module sensor_exposure_gain_mapper #(
   parameter int GAIN_TABLE_ENTRIES = 71
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_sensor_type,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_exposure_in,
   input  logic [15:0] req_gain_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [21:0] rsp_exposure_code,
   output logic [15:0] rsp_gain_code,
   output logic        rsp_unknown_sensor
);
   import segm_pkg::*;

   localparam int ROWS = (GAIN_TABLE_ENTRIES > ROM_ROWS) ? ROM_ROWS : GAIN_TABLE_ENTRIES;
   localparam int SEARCH_BITS = $clog2(ROWS);

   logic [1:0]              sensor_type_ff;
   logic                    ent_valid_ff;
   segm_lane_type           ent_lane_ff;
   segm_lane_type           ent_lane_in;
   logic [DIVIDEND_W-1:0]   dividend;
   logic [GNUM_W-1:0]       gnum;

   logic                    cv [EXPO_STEPS+1];
   logic                    cr [EXPO_STEPS+1];
   segm_lane_type           cl [EXPO_STEPS+1];

   segm_lane_type           last;
   logic                    rsp_valid_ff;
   logic [ECODE_W-1:0]      rsp_exposure_code_ff;
   logic [GAIN_W-1:0]       rsp_gain_code_ff;
   logic                    rsp_unknown_sensor_ff;
   logic [ECODE_W-1:0]      ecode_in;
   logic [GAIN_W-1:0]       gcode_in;
   logic                    unknown_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_type_ff <= TYPE_RECIP;
      end else if (csr_valid) begin
         sensor_type_ff <= csr_sensor_type;
      end
   end

   // input register
   always_comb begin
      unique case (sensor_type_ff)
         TYPE_TABLE:  dividend = DIVIDEND_W'(req_exposure_in);
         TYPE_RECIP:  dividend = DIVIDEND_W'(req_exposure_in) * DIVIDEND_W'(EXPO_MUL_RECIP);
         TYPE_SCALED: dividend = DIVIDEND_W'(req_exposure_in) * DIVIDEND_W'(EXPO_MUL_SCALED);
         default:     dividend = '0;
      endcase
      gnum = RECIP_NUM + GNUM_W'(req_gain_in) - GNUM_W'(1);

      ent_lane_in.stype = sensor_type_ff;
      ent_lane_in.gain  = req_gain_in;
      ent_lane_in.erem  = EXPO_REM_W'(dividend[DIVIDEND_W-1:EXPO_STEPS]);
      ent_lane_in.ebits = dividend[EXPO_STEPS-1:0];
      ent_lane_in.grem  = GAIN_W'(gnum[GNUM_W-1:GAIN_STEPS]);
      ent_lane_in.gbits = gnum[GAIN_STEPS-1:0];
      ent_lane_in.sidx  = '0;
   end

   assign req_ready = !ent_valid_ff || cr[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else if (req_ready) begin
         ent_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         ent_lane_ff <= ent_lane_in;
      end
   end

   assign cv[0] = ent_valid_ff;
   assign cl[0] = ent_lane_ff;

   // cell row
   for (genvar i = 0; i < EXPO_STEPS; i++) begin : g_cell
      segm_cell #(
         .STEP        (i),
         .SEARCH_BITS (SEARCH_BITS),
         .ROWS        (ROWS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[i]),
         .in_ready  (cr[i]),
         .in_lane   (cl[i]),
         .out_valid (cv[i+1]),
         .out_ready (cr[i+1]),
         .out_lane  (cl[i+1])
      );
   end

   // output register
   assign last = cl[EXPO_STEPS];
   assign cr[EXPO_STEPS] = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ecode_in   = last.ebits;
      gcode_in   = '0;
      unknown_in = 1'b0;
      unique case (last.stype)
         TYPE_TABLE: begin
            gcode_in = GAIN_W'(segm_rom_code(last.sidx));
         end
         TYPE_RECIP: begin
            if (last.gain >= UNITY_GAIN) begin
               gcode_in = RECIP_BASE - GAIN_W'(last.gbits);
            end
         end
         TYPE_SCALED: begin
            gcode_in = last.gain;
         end
         default: begin
            ecode_in   = '0;
            unknown_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cr[EXPO_STEPS]) begin
         rsp_valid_ff <= cv[EXPO_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (cr[EXPO_STEPS] && cv[EXPO_STEPS]) begin
         rsp_exposure_code_ff  <= ecode_in;
         rsp_gain_code_ff      <= gcode_in;
         rsp_unknown_sensor_ff <= unknown_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_exposure_code  = rsp_exposure_code_ff;
   assign rsp_gain_code      = rsp_gain_code_ff;
   assign rsp_unknown_sensor = rsp_unknown_sensor_ff;

endmodule

// ===== rtl/core/segm_checker.sv =====
// ----------------------------------------------------------------------------
// segm_checker: port checks of the exposure and gain mapper
// watches the response channel against reset, stalls and the request side
// ----------------------------------------------------------------------------
module segm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [21:0] rsp_exposure_code,
   input logic [15:0] rsp_gain_code,
   input logic        rsp_unknown_sensor
);

   // no word survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response word valid right after reset");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_exposure_code)
         && $stable(rsp_gain_code) && $stable(rsp_unknown_sensor))
      else $error("stalled response word changed");

   // unsupported sensor gives zero codes
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unknown_sensor |-> rsp_exposure_code == 22'd0
         && rsp_gain_code == 16'd0)
      else $error("unknown sensor word carries nonzero codes");

   // an empty output never blocks the request side
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

endmodule

bind sensor_exposure_gain_mapper segm_checker u_segm_checker (.*);
